// ===== rtl/ffha_pkg.sv =====
// ffha_pkg: types, codes and constants of the first-fit heap allocator
// no dependencies; imported by the top level and checker
`default_nettype none
package ffha_pkg;

    localparam int DEF_ARENA_BYTES = 65536;
    localparam int DEF_FREE_SLOTS  = 64;
    localparam int HEADER_BYTES    = 16;
    localparam int MIN_SPLIT_BYTES = 32;
    localparam int GRAN_BYTES      = 8;
    localparam int PAGE_BYTES      = 4096;
    localparam int PAGE_GRAN       = PAGE_BYTES / GRAN_BYTES;
    localparam int HDR_GRAN        = (HEADER_BYTES + GRAN_BYTES - 1) / GRAN_BYTES;
    localparam int MIN_SPLIT_GRAN  = (MIN_SPLIT_BYTES + GRAN_BYTES - 1) / GRAN_BYTES;
    localparam int PAGES_W         = 5;
    localparam logic [PAGES_W-1:0] PAGES_RESET = 5'd16;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_MEMORY  = 3'd1,
        ST_NULL       = 3'd2,
        ST_INVALID    = 3'd3,
        ST_TABLE_FULL = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_AREAD,
        S_ACHK,
        S_FGRAN,
        S_FCHK,
        S_FREAD,
        S_FSCAN,
        S_FDEC,
        S_SHR,
        S_SHW,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op         operation;
        logic [15:0] request_bytes;
        logic [15:0] block_offset;
    } t_in_beat;

    typedef struct packed {
        t_status     status;
        logic [15:0] user_offset;
        logic [16:0] used_bytes;
    } t_out_beat;

endpackage
`default_nettype wire

// ===== rtl/first_fit_heap_allocator_top.sv =====
// first_fit_heap_allocator_top: free segment table and granted-block table in rams
// depends on ffha_pkg and ffha_ram
// allocate reads and checks each free segment scanned, moves table entries on removal
//   and records the block; free checks the granted-block entry, reads the segments below
//   the block and the first one above, merges or inserts, moves entries and records it
// one beat at a time; the next beat can be taken in the cycle after the result is loaded
// reset and each arena_pages write start a clearing pass over all ARENA_BYTES/8 granule entries
`default_nettype none
module first_fit_heap_allocator_top
    import ffha_pkg::*;
#(
    parameter int ARENA_BYTES = DEF_ARENA_BYTES,
    parameter int FREE_SLOTS  = DEF_FREE_SLOTS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [PAGES_W-1:0] i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_beat           i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_beat               o_out_data
);
    localparam int GRANULES = ARENA_BYTES / GRAN_BYTES;
    localparam int MAX_PAGES = ARENA_BYTES / PAGE_BYTES;
    localparam int GW  = $clog2(GRANULES);
    localparam int LW  = GW + 1;
    localparam int SW  = GW + LW;
    localparam int CW  = (LW + 1 > 16) ? LW + 1 : 16;
    localparam int AW  = $clog2(FREE_SLOTS);
    localparam int IW  = $clog2(FREE_SLOTS + 1);
    localparam int UBW = ($clog2(ARENA_BYTES + 1) > 17) ? $clog2(ARENA_BYTES + 1) : 17;
    localparam int PSH = $clog2(PAGE_GRAN);

    t_state             r_state, n_state;
    logic [GW-1:0]      r_clr, n_clr;
    logic [IW-1:0]      r_count, n_count;
    logic [UBW-1:0]     r_bytes, n_bytes;
    logic [PAGES_W-1:0] r_pages, n_pages;
    logic               r_out_valid, n_out_valid;
    t_out_beat          r_out, n_out;
    t_op                r_op, n_op;
    logic [CW-1:0]      r_need, n_need;
    logic [GW-1:0]      r_g, n_g;
    logic [LW-1:0]      r_size, n_size;
    logic [IW-1:0]      r_idx, n_idx;
    logic [IW-1:0]      r_shend, n_shend;
    logic               r_up, n_up;
    logic               r_ins, n_ins;
    logic               r_curv, n_curv;
    logic [GW-1:0]      r_prev_start, n_prev_start;
    logic [LW-1:0]      r_prev_len, n_prev_len;
    logic [GW-1:0]      r_cur_start, n_cur_start;
    logic [LW-1:0]      r_cur_len, n_cur_len;
    t_status            r_status, n_status;
    logic [15:0]        r_user, n_user;

    logic          seg_we;
    logic [AW-1:0] seg_waddr;
    logic [SW-1:0] seg_wdata, seg_rdata;
    logic          gr_we;
    logic [LW:0]   gr_wdata, gr_rdata;

    ffha_ram #(.WIDTH(SW), .DEPTH(FREE_SLOTS)) u_seg_ram (
        .i_clk  (i_clk),
        .i_we   (seg_we),
        .i_waddr(seg_waddr),
        .i_wdata(seg_wdata),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(seg_rdata)
    );

    ffha_ram #(.WIDTH(LW + 1), .DEPTH(GRANULES)) u_gr_ram (
        .i_clk  (i_clk),
        .i_we   (gr_we),
        .i_waddr((r_state == S_CLR) ? r_clr : r_g),
        .i_wdata(gr_wdata),
        .i_raddr(r_g),
        .o_rdata(gr_rdata)
    );

    // decoded conditions
    logic               accept, out_free;
    logic [GW-1:0]      rd_start;
    logic [LW-1:0]      rd_len;
    logic               fit, split, below, left, right;
    logic [LW-1:0]      rem;
    logic [IW-1:0]      idx_inc, idx_dec;
    logic [16:0]        req_one;
    logic [13:0]        req_gran;
    logic [15:0]        off_d;
    logic [12:0]        off_g;
    logic               off_bad;
    logic [PAGES_W-1:0] pages_c;
    logic [LW-1:0]      init_len;
    logic [LW+2:0]      size8;

    assign accept   = i_in_valid && (r_state == S_IDLE) && !i_cfg_we;
    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_start = seg_rdata[SW-1 -: GW];
    assign rd_len   = seg_rdata[LW-1:0];
    assign fit      = CW'(rd_len) >= r_need;
    assign rem      = LW'(CW'(rd_len) - r_need);
    assign split    = rem >= LW'(MIN_SPLIT_GRAN);
    assign below    = rd_start < r_g;
    assign left     = (r_idx != '0) &&
                      ((LW + 1)'(r_prev_start) + (LW + 1)'(r_prev_len) == (LW + 1)'(r_g));
    assign right    = r_curv && ((LW + 1)'(r_g) + (LW + 1)'(r_size) == (LW + 1)'(r_cur_start));
    assign idx_inc  = IW'(r_idx + 1'b1);
    assign idx_dec  = IW'(r_idx - 1'b1);
    assign req_one  = (i_in_data.request_bytes == '0) ? 17'd1 : {1'b0, i_in_data.request_bytes};
    assign req_gran = 14'((req_one + 17'd7) >> 3);
    assign off_d    = i_in_data.block_offset - 16'(HEADER_BYTES);
    assign off_g    = off_d[15:3];
    assign off_bad  = (i_in_data.block_offset < 16'(HEADER_BYTES)) || (off_d[2:0] != 3'b000) ||
                      (int'(off_g) >= GRANULES);
    assign pages_c  = (r_pages == '0) ? PAGES_W'(1) :
                      ((int'(r_pages) > MAX_PAGES) ? PAGES_W'(MAX_PAGES) : r_pages);
    assign init_len = LW'(LW'(pages_c) << PSH);
    assign size8    = {r_size, 3'b000};

    // next state
    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            n_state = S_CLR;
        end else begin
            unique case (r_state)
                S_CLR:   if (r_clr == GW'(GRANULES - 1)) n_state = S_IDLE;
                S_IDLE: begin
                    if (accept) begin
                        if (i_in_data.operation == OP_ALLOC) begin
                            n_state = (r_count == '0) ? S_DONE : S_AREAD;
                        end else if (i_in_data.block_offset == '0 || off_bad) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_FGRAN;
                        end
                    end
                end
                S_AREAD: n_state = S_ACHK;
                S_ACHK: begin
                    if (fit) begin
                        n_state = (split || idx_inc >= r_count) ? S_FIN : S_SHR;
                    end else begin
                        n_state = (idx_inc >= r_count) ? S_DONE : S_AREAD;
                    end
                end
                S_FGRAN: n_state = S_FCHK;
                S_FCHK: begin
                    if (!gr_rdata[LW]) n_state = S_DONE;
                    else n_state = (r_count == '0) ? S_FDEC : S_FREAD;
                end
                S_FREAD: n_state = S_FSCAN;
                S_FSCAN: n_state = (below && idx_inc < r_count) ? S_FREAD : S_FDEC;
                S_FDEC: begin
                    if (left && right) begin
                        n_state = (idx_inc < r_count) ? S_SHR : S_FIN;
                    end else if (left || right) begin
                        n_state = S_FIN;
                    end else if (int'(r_count) >= FREE_SLOTS) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = (r_idx < r_count) ? S_SHR : S_FIN;
                    end
                end
                S_SHR:   n_state = S_SHW;
                S_SHW: begin
                    if (r_up) n_state = (r_idx == r_shend) ? S_FIN : S_SHR;
                    else n_state = (idx_inc < r_shend) ? S_SHR : S_FIN;
                end
                S_FIN:   n_state = S_DONE;
                S_DONE:  if (out_free) n_state = S_IDLE;
                default: n_state = S_CLR;
            endcase
        end
    end

    // datapath and ram strobes
    always_comb begin
        n_clr        = r_clr;
        n_count      = r_count;
        n_bytes      = r_bytes;
        n_pages      = r_pages;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        n_op         = r_op;
        n_need       = r_need;
        n_g          = r_g;
        n_size       = r_size;
        n_idx        = r_idx;
        n_shend      = r_shend;
        n_up         = r_up;
        n_ins        = r_ins;
        n_curv       = r_curv;
        n_prev_start = r_prev_start;
        n_prev_len   = r_prev_len;
        n_cur_start  = r_cur_start;
        n_cur_len    = r_cur_len;
        n_status     = r_status;
        n_user       = r_user;
        seg_we       = 1'b0;
        seg_waddr    = r_idx[AW-1:0];
        seg_wdata    = seg_rdata;
        gr_we        = 1'b0;
        gr_wdata     = '0;
        if (i_cfg_we) begin
            n_pages = i_cfg_data;
            n_clr   = '0;
            n_count = IW'(1);
            n_bytes = '0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    gr_we = 1'b1;
                    if (r_clr == '0) begin
                        seg_we    = 1'b1;
                        seg_waddr = '0;
                        seg_wdata = {GW'(0), init_len};
                    end
                    n_clr = GW'(r_clr + 1'b1);
                end
                S_IDLE: begin
                    if (accept) begin
                        n_op     = i_in_data.operation;
                        n_need   = CW'(req_gran) + CW'(HDR_GRAN);
                        n_g      = GW'(off_g);
                        n_idx    = '0;
                        n_ins    = 1'b0;
                        n_curv   = 1'b0;
                        n_user   = '0;
                        n_status = ST_OK;
                        if (i_in_data.operation == OP_ALLOC) begin
                            if (r_count == '0) n_status = ST_NO_MEMORY;
                        end else if (i_in_data.block_offset == '0) begin
                            n_status = ST_NULL;
                        end else if (off_bad) begin
                            n_status = ST_INVALID;
                        end
                    end
                end
                S_ACHK: begin
                    if (fit) begin
                        n_g = rd_start;
                        if (split) begin
                            seg_we    = 1'b1;
                            seg_wdata = {GW'(CW'(rd_start) + r_need), rem};
                            n_size    = LW'(r_need);
                        end else begin
                            n_size  = rd_len;
                            n_shend = r_count;
                            n_count = IW'(r_count - 1'b1);
                            n_idx   = idx_inc;
                            n_up    = 1'b0;
                        end
                    end else begin
                        n_idx = idx_inc;
                        if (idx_inc >= r_count) n_status = ST_NO_MEMORY;
                    end
                end
                S_FCHK: begin
                    n_size = gr_rdata[LW-1:0];
                    if (!gr_rdata[LW]) n_status = ST_INVALID;
                end
                S_FSCAN: begin
                    if (below) begin
                        n_prev_start = rd_start;
                        n_prev_len   = rd_len;
                        n_idx        = idx_inc;
                    end else begin
                        n_curv      = 1'b1;
                        n_cur_start = rd_start;
                        n_cur_len   = rd_len;
                    end
                end
                S_FDEC: begin
                    if (left && right) begin
                        seg_we    = 1'b1;
                        seg_waddr = idx_dec[AW-1:0];
                        seg_wdata = {r_prev_start, LW'(r_prev_len + r_size + r_cur_len)};
                        n_shend   = r_count;
                        n_count   = IW'(r_count - 1'b1);
                        n_idx     = idx_inc;
                        n_up      = 1'b0;
                    end else if (left) begin
                        seg_we    = 1'b1;
                        seg_waddr = idx_dec[AW-1:0];
                        seg_wdata = {r_prev_start, LW'(r_prev_len + r_size)};
                    end else if (right) begin
                        seg_we    = 1'b1;
                        seg_wdata = {r_g, LW'(r_cur_len + r_size)};
                    end else if (int'(r_count) >= FREE_SLOTS) begin
                        n_status = ST_TABLE_FULL;
                    end else begin
                        n_ins   = 1'b1;
                        n_shend = r_idx;
                        n_up    = 1'b1;
                        n_count = IW'(r_count + 1'b1);
                        if (r_idx < r_count) n_idx = IW'(r_count - 1'b1);
                    end
                end
                S_SHW: begin
                    seg_we = 1'b1;
                    if (r_up) begin
                        seg_waddr = idx_inc[AW-1:0];
                        if (r_idx != r_shend) n_idx = idx_dec;
                    end else begin
                        seg_waddr = idx_dec[AW-1:0];
                        n_idx     = idx_inc;
                    end
                end
                S_FIN: begin
                    gr_we    = 1'b1;
                    gr_wdata = {(r_op == OP_ALLOC), r_size};
                    if (r_ins) begin
                        seg_we    = 1'b1;
                        seg_waddr = r_shend[AW-1:0];
                        seg_wdata = {r_g, r_size};
                    end
                    if (r_op == OP_ALLOC) begin
                        n_bytes = UBW'(r_bytes + UBW'(size8));
                        n_user  = 16'({r_g, 3'b000}) + 16'(HEADER_BYTES);
                    end else if (r_bytes >= UBW'(size8)) begin
                        n_bytes = UBW'(r_bytes - UBW'(size8));
                    end else begin
                        n_bytes = '0;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '{status: r_status, user_offset: r_user,
                                        used_bytes: r_bytes[16:0]};
                    end
                end
                S_AREAD, S_FGRAN, S_FREAD, S_SHR: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_count     <= IW'(1);
            r_bytes     <= '0;
            r_pages     <= PAGES_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_bytes     <= n_bytes;
            r_pages     <= n_pages;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out        <= n_out;
        r_op         <= n_op;
        r_need       <= n_need;
        r_g          <= n_g;
        r_size       <= n_size;
        r_idx        <= n_idx;
        r_shend      <= n_shend;
        r_up         <= n_up;
        r_ins        <= n_ins;
        r_curv       <= n_curv;
        r_prev_start <= n_prev_start;
        r_prev_len   <= n_prev_len;
        r_cur_start  <= n_cur_start;
        r_cur_len    <= n_cur_len;
        r_status     <= n_status;
        r_user       <= n_user;
    end

    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_we;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

// ===== rtl/ffha_ram.sv =====
// ffha_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/ffha_chk.sv =====
// ffha_chk: port-level checks of the heap allocator, bound to the top level
// depends on ffha_pkg and first_fit_heap_allocator_top
`default_nettype none
module ffha_chk
    import ffha_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_cfg_we,
    input wire logic [PAGES_W-1:0] i_cfg_data,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire t_in_beat           i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire t_out_beat          o_out_data
);
    // one beat at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a beat is in work");

    // arena write starts the clearing pass
    a_clear_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_in_stall)
        else $error("input open right after arena write");

    a_offset_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> (o_out_data.user_offset == '0))
        else $error("user offset on failed beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");
endmodule

bind first_fit_heap_allocator_top ffha_chk u_ffha_chk (.*);
`default_nettype wire
